[rtl/pwc_pkg.sv]
`default_nettype none

package pwc_pkg;

  // Operating modes; the encoding is also the value on the status output.
  typedef enum logic [2:0] {
    MODE_IDLE       = 3'd0,
    MODE_TIMING     = 3'd1,
    MODE_AUTO_CLOSE = 3'd2,
    MODE_MAN_CLOSE  = 3'd3,
    MODE_AUTO_OPEN  = 3'd4,
    MODE_MAN_OPEN   = 3'd5,
    MODE_PAUSE      = 3'd6,
    MODE_REVERSE    = 3'd7
  } mode_t;

  // Configuration register indexes.
  localparam logic [2:0] REG_AUTO_HOLD  = 3'd0;
  localparam logic [2:0] REG_MOVE_PER   = 3'd1;
  localparam logic [2:0] REG_PAUSE      = 3'd2;
  localparam logic [2:0] REG_REVERSE    = 3'd3;
  localparam logic [2:0] REG_MAX_POS    = 3'd4;

  // Register values after reset.
  localparam logic [15:0] AUTO_HOLD_RST = 16'd1000;
  localparam logic [15:0] MOVE_PER_RST  = 16'd100;
  localparam logic [15:0] PAUSE_RST     = 16'd500;
  localparam logic [15:0] REVERSE_RST   = 16'd500;
  localparam logic [7:0]  MAX_POS_RST   = 8'd40;

  // Saturating 16-bit increment used by all tick counters.
  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    sat_inc = (v == 16'hFFFF) ? 16'hFFFF : v + 16'd1;
  endfunction

endpackage

`default_nettype wire

[rtl/power_window_controller.sv]
`default_nettype none

// Power window controller. Every input transfer is one sampled tick carrying
// the button, lock, limit switch and obstacle levels; every tick yields exactly
// one result transfer with the motor drive, buzzer, tracked position, mode
// status and lock indication as they stand at the end of that tick. The mode
// logic, press timer, move timer and position are updated in a single pass at
// the clock edge that takes the tick, and the result lands in an output
// register. With the output side draining, one tick is taken in every cycle;
// the input is stalled only while a result waits in the output register and
// the output side stalls. Configuration registers (auto hold, move period,
// obstacle pause, reverse time, maximum position) are written through the cfg
// channel, which is always ready, and should be written only while no tick is
// in flight.
module power_window_controller
  import pwc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,

  // Configuration write channel.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,

  // Tick input channel.
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        driver_up,
  input  wire logic        driver_down,
  input  wire logic        passenger_up,
  input  wire logic        passenger_down,
  input  wire logic        passenger_lock,
  input  wire logic        upper_limit,
  input  wire logic        lower_limit,
  input  wire logic        obstacle,

  // Result output channel.
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             close_drive,
  output logic             open_drive,
  output logic             buzzer,
  output logic [7:0]       position,
  output logic [2:0]       status,
  output logic             passenger_locked
);

  // Configuration registers.
  logic [15:0] auto_hold_ticks;
  logic [15:0] move_period_ticks;
  logic [15:0] obstacle_pause_ticks;
  logic [15:0] reverse_ticks;
  logic [7:0]  max_position;

  // Controller state.
  mode_t       mode, mode_next;
  logic        press_is_up, press_is_up_next;
  logic        press_from_driver, press_from_driver_next;
  logic [15:0] phase_timer, phase_timer_next;
  logic [15:0] move_timer, move_timer_next;
  logic [7:0]  window_position, window_position_next;

  logic        in_accept;
  logic        drv_req;
  logic        pas_req;
  logic        held;
  logic        travel;
  logic [7:0]  pos_forced;
  logic [7:0]  pos_lim;
  logic [15:0] pt_inc;
  logic [15:0] mt_inc;

  assign cfg_ready = 1'b1;

  // A waiting result that cannot leave blocks the next tick.
  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      auto_hold_ticks      <= AUTO_HOLD_RST;
      move_period_ticks    <= MOVE_PER_RST;
      obstacle_pause_ticks <= PAUSE_RST;
      reverse_ticks        <= REVERSE_RST;
      max_position         <= MAX_POS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_AUTO_HOLD: auto_hold_ticks      <= cfg_data;
        REG_MOVE_PER:  move_period_ticks    <= cfg_data;
        REG_PAUSE:     obstacle_pause_ticks <= cfg_data;
        REG_REVERSE:   reverse_ticks        <= cfg_data;
        REG_MAX_POS:   max_position         <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign drv_req = driver_up || driver_down;
  assign pas_req = !passenger_lock && (passenger_up || passenger_down);

  // Whether the button that started the current press is still held.
  always_comb begin
    if (press_from_driver) begin
      held = press_is_up ? driver_up : driver_down;
    end else begin
      held = press_is_up ? passenger_up : passenger_down;
    end
  end

  // Limit switches force the tracked position first (upper wins), then the
  // position is clamped to the configured maximum.
  always_comb begin
    if (upper_limit) begin
      pos_forced = max_position;
    end else if (lower_limit) begin
      pos_forced = 8'd0;
    end else begin
      pos_forced = window_position;
    end
    pos_lim = (pos_forced > max_position) ? max_position : pos_forced;
  end

  // Next-state logic for one tick.
  always_comb begin
    mode_next              = mode;
    press_is_up_next       = press_is_up;
    press_from_driver_next = press_from_driver;
    phase_timer_next       = phase_timer;
    move_timer_next        = move_timer;
    window_position_next   = pos_lim;
    travel                 = 1'b0;
    pt_inc                 = sat_inc(phase_timer);
    mt_inc                 = 16'd0;

    if (mode != MODE_IDLE && mode != MODE_PAUSE && mode != MODE_REVERSE &&
        !press_from_driver && (drv_req || passenger_lock)) begin
      // A passenger press is cut short by a driver button or the lock.
      if (drv_req) begin
        press_from_driver_next = 1'b1;
        press_is_up_next       = driver_up;
        phase_timer_next       = 16'd0;
        mode_next              = MODE_TIMING;
      end else begin
        mode_next = MODE_IDLE;
      end
    end else begin
      unique case (mode)
        MODE_IDLE: begin
          if (drv_req || pas_req) begin
            press_from_driver_next = drv_req;
            press_is_up_next       = drv_req ? driver_up : passenger_up;
            phase_timer_next       = 16'd0;
            mode_next              = MODE_TIMING;
          end
        end
        MODE_TIMING: begin
          if (held) begin
            phase_timer_next = pt_inc;
            if (pt_inc > auto_hold_ticks) begin
              mode_next       = press_is_up ? MODE_MAN_CLOSE : MODE_MAN_OPEN;
              move_timer_next = 16'd0;
              travel          = 1'b1;
            end
          end else begin
            mode_next       = press_is_up ? MODE_AUTO_CLOSE : MODE_AUTO_OPEN;
            move_timer_next = 16'd0;
            travel          = 1'b1;
          end
        end
        MODE_PAUSE: begin
          if (pt_inc >= obstacle_pause_ticks) begin
            mode_next        = MODE_REVERSE;
            phase_timer_next = 16'd0;
            move_timer_next  = 16'd0;
          end else begin
            phase_timer_next = pt_inc;
          end
        end
        MODE_REVERSE: begin
          if (lower_limit || phase_timer >= reverse_ticks) begin
            mode_next = MODE_IDLE;
          end else begin
            phase_timer_next = pt_inc;
            mt_inc           = sat_inc(move_timer);
            if (mt_inc >= move_period_ticks) begin
              move_timer_next = 16'd0;
              if (pos_lim != 8'd0) begin
                window_position_next = pos_lim - 8'd1;
              end
            end else begin
              move_timer_next = mt_inc;
            end
          end
        end
        MODE_AUTO_CLOSE, MODE_MAN_CLOSE, MODE_AUTO_OPEN, MODE_MAN_OPEN: begin
          travel = 1'b1;
        end
        default: ;
      endcase

      if (travel) begin
        mt_inc = sat_inc(move_timer_next);
        if (mode_next == MODE_AUTO_CLOSE || mode_next == MODE_MAN_CLOSE) begin
          if (upper_limit || pos_lim >= max_position ||
              (mode_next == MODE_MAN_CLOSE && !held)) begin
            mode_next = MODE_IDLE;
          end else if (obstacle) begin
            mode_next        = MODE_PAUSE;
            phase_timer_next = 16'd0;
          end else if (mt_inc >= move_period_ticks) begin
            move_timer_next      = 16'd0;
            window_position_next = pos_lim + 8'd1;
          end else begin
            move_timer_next = mt_inc;
          end
        end else begin
          if (lower_limit || pos_lim == 8'd0 ||
              (mode_next == MODE_MAN_OPEN && !held)) begin
            mode_next = MODE_IDLE;
          end else if (mt_inc >= move_period_ticks) begin
            move_timer_next      = 16'd0;
            window_position_next = pos_lim - 8'd1;
          end else begin
            move_timer_next = mt_inc;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode              <= MODE_IDLE;
      press_is_up       <= 1'b0;
      press_from_driver <= 1'b0;
      phase_timer       <= 16'd0;
      move_timer        <= 16'd0;
      window_position   <= 8'd0;
    end else if (in_accept) begin
      mode              <= mode_next;
      press_is_up       <= press_is_up_next;
      press_from_driver <= press_from_driver_next;
      phase_timer       <= phase_timer_next;
      move_timer        <= move_timer_next;
      window_position   <= window_position_next;
    end
  end

  // Output register: loaded with each tick's result, held while stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      close_drive      <= (mode_next == MODE_AUTO_CLOSE) ||
                          (mode_next == MODE_MAN_CLOSE);
      open_drive       <= (mode_next == MODE_AUTO_OPEN) ||
                          (mode_next == MODE_MAN_OPEN) ||
                          (mode_next == MODE_REVERSE);
      buzzer           <= (mode_next == MODE_PAUSE) ||
                          (mode_next == MODE_REVERSE);
      position         <= window_position_next;
      status           <= mode_next;
      passenger_locked <= passenger_lock;
    end
  end

endmodule

`default_nettype wire

[bench/power_window_controller_test.sv]
`timescale 1ns / 100ps

module power_window_controller_test;
  import pwc_pkg::*;

  // One sampled tick as it is driven onto the input channel. The member order
  // matches the concatenation of the payload ports in the driver below.
  typedef struct packed {
    logic driver_up;
    logic driver_down;
    logic passenger_up;
    logic passenger_down;
    logic passenger_lock;
    logic upper_limit;
    logic lower_limit;
    logic obstacle;
  } tick_t;

  // What the block reports at the end of one tick.
  typedef struct packed {
    logic       close_drive;
    logic       open_drive;
    logic       buzzer;
    logic [7:0] position;
    logic [2:0] status;
    logic       locked;
  } window_state_t;

  // A run with no transfer of any kind for this many cycles is hung.
  localparam int QUIET_LIMIT = 500;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = REG_AUTO_HOLD;
  logic [15:0] cfg_data = '0;

  logic in_valid = 1'b0;
  logic in_stall;
  logic driver_up = 1'b0;
  logic driver_down = 1'b0;
  logic passenger_up = 1'b0;
  logic passenger_down = 1'b0;
  logic passenger_lock = 1'b0;
  logic upper_limit = 1'b0;
  logic lower_limit = 1'b0;
  logic obstacle = 1'b0;

  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       close_drive;
  logic       open_drive;
  logic       buzzer;
  logic [7:0] position;
  logic [2:0] status;
  logic       passenger_locked;

  power_window_controller i_dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .driver_up       (driver_up),
    .driver_down     (driver_down),
    .passenger_up    (passenger_up),
    .passenger_down  (passenger_down),
    .passenger_lock  (passenger_lock),
    .upper_limit     (upper_limit),
    .lower_limit     (lower_limit),
    .obstacle        (obstacle),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .close_drive     (close_drive),
    .open_drive      (open_drive),
    .buzzer          (buzzer),
    .position        (position),
    .status          (status),
    .passenger_locked(passenger_locked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor. It keeps its own copy of the controller state and of the five
  // configuration registers, and advances them by one tick for every input
  // transfer. The configuration copy is updated when a register write
  // transfer completes, which only happens while nothing is in flight.
  // ---------------------------------------------------------------------------
  logic [15:0] hold_ticks  = AUTO_HOLD_RST;
  logic [15:0] move_period = MOVE_PER_RST;
  logic [15:0] pause_ticks = PAUSE_RST;
  logic [15:0] rev_ticks   = REVERSE_RST;
  logic [7:0]  max_pos     = MAX_POS_RST;

  mode_t       win_mode     = MODE_IDLE;
  logic        press_up     = 1'b0;
  logic        press_drv    = 1'b0;
  logic [15:0] phase_count  = '0;
  logic [15:0] travel_count = '0;
  logic [7:0]  win_pos      = '0;

  function automatic logic [15:0] bump(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  // Advances the travel timer; true when the position is due to move one unit.
  // A zero period makes every tick a step.
  function automatic logic motor_step_due();
    travel_count = bump(travel_count);
    if (travel_count >= move_period) begin
      travel_count = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic window_state_t advance_window(input tick_t t);
    logic drv_req;
    logic pas_req;
    logic held;
    logic travel;
    window_state_t r;
    drv_req = t.driver_up | t.driver_down;
    pas_req = !t.passenger_lock && (t.passenger_up | t.passenger_down);
    travel  = 1'b0;

    // The limit switches override the tracked position before anything else;
    // the upper one wins when both are closed.
    if (t.upper_limit) begin
      win_pos = max_pos;
    end else if (t.lower_limit) begin
      win_pos = '0;
    end
    if (win_pos > max_pos) begin
      win_pos = max_pos;
    end

    if (press_drv) begin
      held = press_up ? t.driver_up : t.driver_down;
    end else begin
      held = press_up ? t.passenger_up : t.passenger_down;
    end

    // A passenger press in progress is cut short by any driver button or by
    // the lock. A driver button starts timing its own press.
    if (win_mode >= MODE_TIMING && win_mode <= MODE_MAN_OPEN && !press_drv &&
        (drv_req || t.passenger_lock)) begin
      if (drv_req) begin
        press_drv   = 1'b1;
        press_up    = t.driver_up;
        phase_count = '0;
        win_mode    = MODE_TIMING;
      end else begin
        win_mode = MODE_IDLE;
      end
    end else begin
      case (win_mode)
        MODE_IDLE: begin
          if (drv_req || pas_req) begin
            press_drv   = drv_req;
            press_up    = drv_req ? t.driver_up : t.passenger_up;
            phase_count = '0;
            win_mode    = MODE_TIMING;
          end
        end
        MODE_TIMING: begin
          if (held) begin
            phase_count = bump(phase_count);
            if (phase_count > hold_ticks) begin
              win_mode     = press_up ? MODE_MAN_CLOSE : MODE_MAN_OPEN;
              travel_count = '0;
              travel       = 1'b1;
            end
          end else begin
            win_mode     = press_up ? MODE_AUTO_CLOSE : MODE_AUTO_OPEN;
            travel_count = '0;
            travel       = 1'b1;
          end
        end
        MODE_PAUSE: begin
          phase_count = bump(phase_count);
          if (phase_count >= pause_ticks) begin
            win_mode     = MODE_REVERSE;
            phase_count  = '0;
            travel_count = '0;
          end
        end
        MODE_REVERSE: begin
          if (t.lower_limit || phase_count >= rev_ticks) begin
            win_mode = MODE_IDLE;
          end else begin
            phase_count = bump(phase_count);
            if (motor_step_due() && win_pos != 0) begin
              win_pos--;
            end
          end
        end
        default: begin
          travel = 1'b1;
        end
      endcase
    end

    // Travel is evaluated in the tick that starts it as well.
    if (travel) begin
      if (win_mode == MODE_AUTO_CLOSE || win_mode == MODE_MAN_CLOSE) begin
        if (t.upper_limit || win_pos >= max_pos ||
            (win_mode == MODE_MAN_CLOSE && !held)) begin
          win_mode = MODE_IDLE;
        end else if (t.obstacle) begin
          win_mode    = MODE_PAUSE;
          phase_count = '0;
        end else if (motor_step_due()) begin
          win_pos++;
        end
      end else begin
        if (t.lower_limit || win_pos == 0 ||
            (win_mode == MODE_MAN_OPEN && !held)) begin
          win_mode = MODE_IDLE;
        end else if (motor_step_due()) begin
          win_pos--;
        end
      end
    end

    r.close_drive = (win_mode == MODE_AUTO_CLOSE || win_mode == MODE_MAN_CLOSE);
    r.open_drive  = (win_mode == MODE_AUTO_OPEN || win_mode == MODE_MAN_OPEN ||
                     win_mode == MODE_REVERSE);
    r.buzzer      = (win_mode == MODE_PAUSE || win_mode == MODE_REVERSE);
    r.position    = win_pos;
    r.status      = win_mode;
    r.locked      = t.passenger_lock;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Shared bookkeeping between the stimulus, the driver and the monitor.
  // ---------------------------------------------------------------------------
  tick_t         pending_ticks[$];
  window_state_t expected_outputs[$];
  int            ticks_queued = 0;
  int            ticks_taken = 0;
  int            mismatches = 0;
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;

  // Each side draws a wait per item; a percentage of zero gives a stretch
  // with no idling at all.
  function automatic int draw_wait(input int pct);
    return ($urandom_range(0, 99) < pct) ? int'($urandom_range(1, 8)) : 0;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver. At every rising edge it first notes whether the tick on the bus
  // was taken; if so the predictor advances and the expected result is queued.
  // When no tick is held up by a stall it either sits out its drawn gap or
  // presents the next pending tick. The payload never changes while stalled.
  // ---------------------------------------------------------------------------
  tick_t current_tick = '0;
  int    send_gap = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_outputs.push_back(advance_window(current_tick));
        ticks_taken++;
        send_gap = draw_wait(send_idle_pct);
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_ticks.size() != 0) begin
          current_tick = pending_ticks.pop_front();
          {driver_up, driver_down, passenger_up, passenger_down, passenger_lock,
           upper_limit, lower_limit, obstacle} <= current_tick;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor. Every result transfer is compared field by field against the
  // oldest expectation. After each transfer it draws how many cycles to
  // hold stall high before taking the next result.
  // ---------------------------------------------------------------------------
  window_state_t want;
  int            recv_stall = 0;

  task automatic check_field(input string name, input int exp_val, input int got_val);
    if (exp_val != got_val) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_val, got_val);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_outputs.size() == 0) begin
          $error("result transfer with no tick outstanding");
          mismatches++;
        end else begin
          want = expected_outputs.pop_front();
          check_field("close_drive", want.close_drive, close_drive);
          check_field("open_drive", want.open_drive, open_drive);
          check_field("buzzer", want.buzzer, buzzer);
          check_field("position", want.position, position);
          check_field("status", want.status, status);
          check_field("passenger_locked", want.locked, passenger_locked);
        end
        recv_stall = draw_wait(recv_stall_pct);
      end else if (recv_stall > 0) begin
        recv_stall--;
      end
      out_stall <= (recv_stall != 0);
    end
  end

  // Watchdog: any transfer on any channel counts as progress.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  function automatic tick_t mk(input logic du, input logic dd, input logic pu,
                               input logic pd, input logic lk, input logic ul,
                               input logic ll, input logic ob);
    return {du, dd, pu, pd, lk, ul, ll, ob};
  endfunction

  task automatic queue_tick(input tick_t t, input int count);
    repeat (count) begin
      pending_ticks.push_back(t);
      ticks_queued++;
    end
  endtask

  // Waits until every queued tick has been taken and every result has come
  // back. Every tick yields a result, so the block is then idle.
  task automatic wait_drained();
    while (ticks_taken != ticks_queued || expected_outputs.size() != 0) begin
      @(posedge clk);
    end
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_AUTO_HOLD: hold_ticks  = val;
      REG_MOVE_PER:  move_period = val;
      REG_PAUSE:     pause_ticks = val;
      REG_REVERSE:   rev_ticks   = val;
      REG_MAX_POS:   max_pos     = val[7:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [15:0] hold, input logic [15:0] period,
                              input logic [15:0] pause, input logic [15:0] reverse,
                              input logic [7:0] top);
    write_reg(REG_AUTO_HOLD, hold);
    write_reg(REG_MOVE_PER, period);
    write_reg(REG_PAUSE, pause);
    write_reg(REG_REVERSE, reverse);
    write_reg(REG_MAX_POS, {8'd0, top});
  endtask

  // One press of one button: held for a random length around the auto
  // threshold so that both auto and manual travel come up, then released and
  // left to coast. Lock, limits, obstacle and stray buttons show up now and
  // then on top of that, which also breaks some of the sequences.
  task automatic add_press_episode();
    int    hold_len;
    int    coast_len;
    int    i;
    logic  up;
    logic  from_drv;
    logic  lk;
    tick_t t;
    up        = 1'($urandom_range(0, 1));
    from_drv  = 1'($urandom_range(0, 1));
    lk        = ($urandom_range(0, 3) == 0);
    hold_len  = $urandom_range(1, ((hold_ticks < 20) ? int'(hold_ticks) : 20) + 3);
    coast_len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 12);
    for (i = 0; i < hold_len + coast_len; i++) begin
      t = '0;
      if (i < hold_len) begin
        if (from_drv) begin
          t.driver_up   = up;
          t.driver_down = !up;
        end else begin
          t.passenger_up   = up;
          t.passenger_down = !up;
        end
      end
      if ($urandom_range(0, 11) == 0) begin
        {t.driver_up, t.driver_down, t.passenger_up, t.passenger_down} = 4'($urandom);
      end
      t.passenger_lock = lk ^ ($urandom_range(0, 15) == 0);
      t.upper_limit    = ($urandom_range(0, 24) == 0);
      t.lower_limit    = ($urandom_range(0, 24) == 0);
      t.obstacle       = ($urandom_range(0, 9) == 0);
      queue_tick(t, 1);
    end
  endtask

  task automatic run_random(input int count, input int send_pct, input int recv_pct);
    int start;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    start = ticks_queued;
    while (ticks_queued - start < count) begin
      if ($urandom_range(0, 6) == 0) begin
        queue_tick(tick_t'(8'($urandom_range(0, 255))), 1);
      end else begin
        add_press_episode();
      end
    end
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part under the register values after reset: all inputs low,
    // all inputs high (both limits closed, so upper wins and the position
    // jumps to the default maximum), then each limit on its own.
    send_idle_pct  = 30;
    recv_stall_pct = 30;
    queue_tick(mk(0, 0, 0, 0, 0, 0, 0, 0), 1);
    queue_tick(mk(1, 1, 1, 1, 1, 1, 1, 1), 1);
    queue_tick(mk(0, 0, 0, 0, 0, 0, 1, 0), 1);
    queue_tick(mk(0, 0, 0, 0, 0, 1, 0, 0), 1);
    wait_drained();

    // Short timings so that the whole mode cycle fits in a few ticks.
    program_regs(16'd2, 16'd1, 16'd2, 16'd3, 8'd5);
    // Open fully, a short driver press starts auto close, an obstacle stops
    // it, the pause runs out and the window reverses until the time is up.
    queue_tick(mk(0, 0, 0, 0, 0, 0, 1, 0), 1);
    queue_tick(mk(1, 0, 0, 0, 0, 0, 0, 0), 1);
    queue_tick(mk(0, 0, 0, 0, 0, 0, 0, 0), 2);
    queue_tick(mk(0, 0, 0, 0, 0, 0, 0, 1), 1);
    queue_tick(mk(0, 0, 0, 0, 0, 0, 0, 0), 6);
    // Passenger presses both buttons (up wins), then the driver takes over
    // with a long down press that turns into manual open, then releases.
    queue_tick(mk(0, 0, 1, 1, 0, 0, 0, 0), 1);
    queue_tick(mk(0, 1, 0, 0, 0, 1, 0, 0), 1);
    queue_tick(mk(0, 1, 0, 0, 0, 0, 0, 0), 4);
    queue_tick(mk(0, 0, 0, 0, 0, 0, 0, 0), 1);
    // The lock cancels a passenger press and then keeps passenger buttons out.
    queue_tick(mk(0, 0, 0, 1, 0, 0, 0, 0), 1);
    queue_tick(mk(0, 0, 0, 1, 1, 0, 0, 0), 1);
    queue_tick(mk(0, 0, 1, 0, 1, 0, 0, 0), 1);
    wait_drained();

    // Random part over several register settings, the extremes among them.
    // The first setting runs without any idling on either side.
    program_regs(16'd4, 16'd1, 16'd1, 16'd3, 8'd1);
    run_random(150, 0, 0);
    // Zero durations and a zero maximum act as already elapsed.
    program_regs(16'd0, 16'd0, 16'd0, 16'd0, 8'd0);
    run_random(100, 30, 30);
    program_regs(16'd10, 16'd3, 16'd5, 16'd8, 8'd255);
    run_random(150, 60, 20);
    program_regs(AUTO_HOLD_RST, MOVE_PER_RST, PAUSE_RST, REVERSE_RST, MAX_POS_RST);
    run_random(100, 20, 60);
    program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
    run_random(80, 30, 30);
    repeat (3) begin
      program_regs(16'($urandom_range(0, 12)), 16'($urandom_range(0, 4)),
                   16'($urandom_range(0, 6)), 16'($urandom_range(0, 10)),
                   8'($urandom_range(1, 20)));
      run_random(100, $urandom_range(0, 70), $urandom_range(0, 70));
    end

    repeat (5) @(posedge clk);
    if (mismatches == 0 && expected_outputs.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
